// ===== src/mwab_pkg.sv =====
// Shared types, constants and register indexes for the mask wipe alpha blend unit.
package mwab_pkg;

    localparam int unsigned MASK_W    = 16;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned MV_W      = 18;
    localparam int unsigned DIV_STEPS = 8;
    localparam int unsigned NUM_W     = FRAC_W + DIV_STEPS;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    localparam logic [FRAC_W-1:0] WIDE_UNIT  = 17'd131070;
    localparam logic [7:0]        ALPHA_MAX  = 8'hff;
    localparam logic [7:0]        CHROMA_MID = 8'h80;

    localparam logic [1:0] REG_POSITION = 2'd0;
    localparam logic [1:0] REG_BORDER   = 2'd1;
    localparam logic [1:0] REG_WIDE     = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0] mask_level;
        logic [7:0]        luma_in;
        logic [7:0]        cb_in;
        logic [7:0]        cr_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] luma_out;
        logic [7:0] cb_out;
        logic [7:0] cr_out;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    typedef struct packed {
        logic             hidden;
        logic             shown;
        logic [NUM_W-1:0] rem;
        logic [FRAC_W-1:0] den;
        logic [DIV_STEPS-1:0] quo;
        t_yuv             pix;
    } t_div;

endpackage

// ===== src/mask_wipe_alpha_blend_unit.sv =====
// Top level of the mask wipe alpha blend unit: register port and pixel pipeline.
//
// Usage:
//   The input channel carries one beat per pixel: a mask sample and a YUV pixel
//   (i_valid, o_stall, i_in). The output channel returns one AYUV beat per
//   input beat, in order (o_valid, i_stall, o_out). The APB port holds the wipe
//   position, the border width and the mask width select; write them while the
//   pipeline is empty.
//   Throughput is one pixel per cycle while the output is not stalled. From the
//   accepting edge to the output beat, one stage loads the window, one classifies
//   the mask, one forms 255 times the offset, eight stages each resolve one alpha
//   bit of a restoring divider, and one register drives the output.
//   The whole pipeline advances together; it holds only while the output beat
//   is valid and stalled, and o_stall then follows i_stall in the same cycle.
//   Synchronous reset clears all valid bits and the configuration registers to zero.
module mask_wipe_alpha_blend_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  mwab_pkg::t_pix_in             i_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output mwab_pkg::t_pix_out            o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwab_pkg::ADDR_W-1:0]   paddr,
    input  logic [mwab_pkg::DATA_W-1:0]   pwdata,
    output logic [mwab_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mwab_pkg::*;

    localparam int unsigned STAGES = DIV_STEPS + 4;

    logic [15:0]        r_position;
    logic               r_wide;
    logic [15:0]        r_border;
    logic [STAGES-1:0]  r_vld;
    logic               en;
    logic               wr;

    logic [MV_W-1:0]    r_a_mv;
    logic [FRAC_W-1:0]  r_a_lo;
    logic [FRAC_W-1:0]  r_a_hi;
    t_yuv               r_a_pix;

    logic               r_b_hidden;
    logic               r_b_shown;
    logic [FRAC_W-1:0]  r_b_diff;
    logic [FRAC_W-1:0]  r_b_den;
    t_yuv               r_b_pix;

    t_div               r_div [DIV_STEPS+1];
    t_div               n_div [DIV_STEPS+1];
    t_pix_out           r_out;
    t_pix_out           n_out;

    logic [MASK_W-1:0]  m;
    logic [MV_W:0]      lo_raw;
    logic [MV_W-1:0]    hi_raw;
    logic [FRAC_W-1:0]  n_lo;
    logic [FRAC_W-1:0]  n_hi;
    logic [MV_W-1:0]    diff_full;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign o_stall = r_vld[STAGES-1] && i_stall;
    assign en      = !o_stall;
    assign o_valid = r_vld[STAGES-1];
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_border   <= '0;
            r_wide     <= 1'b0;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_POSITION: r_position <= pwdata[15:0];
                REG_BORDER:   r_border   <= pwdata[15:0];
                REG_WIDE:     r_wide     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POSITION: prdata = {16'd0, r_position};
            REG_BORDER:   prdata = {16'd0, r_border};
            REG_WIDE:     prdata = {31'd0, r_wide};
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        m      = r_wide ? i_in.mask_level : {i_in.mask_level[7:0], i_in.mask_level[7:0]};
        lo_raw = {2'b00, r_position, 1'b0} - {3'b000, r_border};
        hi_raw = {1'b0, r_position, 1'b0} + {2'b00, r_border};
        if (lo_raw[MV_W]) begin
            n_lo = '0;
            n_hi = '0;
        end else if (hi_raw > {1'b0, WIDE_UNIT}) begin
            n_lo = WIDE_UNIT;
            n_hi = WIDE_UNIT;
        end else begin
            n_lo = lo_raw[FRAC_W-1:0];
            n_hi = hi_raw[FRAC_W-1:0];
        end
        diff_full = r_a_mv - {1'b0, r_a_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mv  <= {1'b0, m, 1'b0};
            r_a_lo  <= n_lo;
            r_a_hi  <= n_hi;
            r_a_pix <= '{y: i_in.luma_in, u: i_in.cb_in, v: i_in.cr_in};

            r_b_hidden <= r_a_mv < {1'b0, r_a_lo};
            r_b_shown  <= r_a_mv >= {1'b0, r_a_hi};
            r_b_diff   <= diff_full[FRAC_W-1:0];
            r_b_den    <= r_a_hi - r_a_lo;
            r_b_pix    <= r_a_pix;

            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_div[j] <= n_div[j];
            end
            r_out <= n_out;
        end
    end

    always_comb begin
        logic [NUM_W-1:0] trial;
        n_div[0].hidden = r_b_hidden;
        n_div[0].shown  = r_b_shown;
        n_div[0].rem    = ({{DIV_STEPS{1'b0}}, r_b_diff} << DIV_STEPS)
                        - {{DIV_STEPS{1'b0}}, r_b_diff};
        n_div[0].den    = r_b_den;
        n_div[0].quo    = '0;
        n_div[0].pix    = r_b_pix;
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial        = {{DIV_STEPS{1'b0}}, r_div[j].den} << (DIV_STEPS - 1 - j);
            n_div[j+1]   = r_div[j];
            n_div[j+1].quo = {r_div[j].quo[DIV_STEPS-2:0], r_div[j].rem >= trial};
            if (r_div[j].rem >= trial) begin
                n_div[j+1].rem = r_div[j].rem - trial;
            end
        end
    end

    always_comb begin
        if (r_div[DIV_STEPS].hidden) begin
            n_out = '{alpha_out: 8'd0, luma_out: 8'd0,
                      cb_out: CHROMA_MID, cr_out: CHROMA_MID};
        end else begin
            n_out.alpha_out = r_div[DIV_STEPS].shown ? ALPHA_MAX : r_div[DIV_STEPS].quo;
            n_out.luma_out  = r_div[DIV_STEPS].pix.y;
            n_out.cb_out    = r_div[DIV_STEPS].pix.u;
            n_out.cr_out    = r_div[DIV_STEPS].pix.v;
        end
    end

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending output beat");

    a_ramp_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-2] && !r_div[DIV_STEPS].hidden && !r_div[DIV_STEPS].shown)
        |-> (r_div[DIV_STEPS].quo != ALPHA_MAX))
        else $error("ramp alpha reached full scale");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule
